### rtl/core/sorted_array_table_unit_defines.svh
// Assertion macros used by the sorted array table checker.
`ifndef SORTED_ARRAY_TABLE_UNIT_DEFINES_SVH
`define SORTED_ARRAY_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clock, quiet while reset is high.
`define SAT_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, quiet while reset is high.
`define SAT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/sat_pkg.sv
// Shared types, codes and widths of the sorted array table.
package sat_pkg;

   localparam int DEPTH_DEF      = 16;
   localparam int VALUE_BITS_DEF = 32;

   localparam int CMD_W      = 3;
   localparam int VAL_IN_W   = 32;
   localparam int IDX_W      = 5;
   localparam int STATUS_W   = 2;
   localparam int POS_W      = 5;
   localparam int COUNT_W    = 5;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_PAD_W  = RSP_DATA_W - STATUS_W - POS_W - COUNT_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND,
      CMD_INSERT_AT,
      CMD_INSERT_SORTED,
      CMD_INSERT_UNIQUE,
      CMD_DELETE_AT,
      CMD_FIND,
      CMD_SORT_UNIQUE,
      CMD_CLEAR
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK,
      ST_MISS,
      ST_FULL,
      ST_RANGE
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic cap_req;
      logic cmp;
      logic exec;
      logic sort_step;
      logic dup_del;
      logic load_rsp;
   } ctl_type;

   // datapath to controller
   typedef struct packed {
      logic is_sort;
      logic sort_last;
      logic dup_found;
      logic rsp_free;
   } sts_type;

endpackage

### rtl/core/sat_ctrl.sv
// Sequencer of the sorted array table: steps one command through its phases.
module sat_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  sat_pkg::sts_type  sts,
   output sat_pkg::ctl_type  ctl
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CMP,
      S_EXEC,
      S_SORT,
      S_DCMP,
      S_DDEL,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      ctl        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctl.cap_req = 1'b1;
               state_in    = S_CMP;
            end
         end
         S_CMP: begin
            ctl.cmp  = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            ctl.exec = 1'b1;
            state_in = sts.is_sort ? S_SORT : S_DONE;
         end
         S_SORT: begin
            ctl.sort_step = 1'b1;
            if (sts.sort_last) begin
               state_in = S_DCMP;
            end
         end
         S_DCMP: begin
            ctl.cmp  = 1'b1;
            state_in = S_DDEL;
         end
         S_DDEL: begin
            // drop one adjacent duplicate per round, then recheck
            if (sts.dup_found) begin
               ctl.dup_del = 1'b1;
               state_in    = S_DCMP;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               ctl.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/sat_datapath.sv
// Datapath of the sorted array table: entry cells, flags, count and result word.
module sat_datapath #(
   parameter int DEPTH      = sat_pkg::DEPTH_DEF,
   parameter int VALUE_BITS = sat_pkg::VALUE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [sat_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  sat_pkg::ctl_type                ctl,
   output sat_pkg::sts_type                sts,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [sat_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = (CW > sat_pkg::IDX_W) ? CW : sat_pkg::IDX_W;
   localparam int PW = $clog2(DEPTH);

   // request fields
   sat_pkg::cmd_type              req_cmd;
   logic [sat_pkg::VAL_IN_W-1:0]  req_raw;
   logic [63:0]                   req_wide;
   logic [VALUE_BITS-1:0]         req_val;
   logic [sat_pkg::IDX_W-1:0]     req_idx;

   // stored state
   logic [VALUE_BITS-1:0]  cell_ff [DEPTH];
   logic [VALUE_BITS-1:0]  cell_in [DEPTH];
   logic [CW-1:0]          count_ff, count_in;
   sat_pkg::cmd_type       cmd_ff;
   logic [VALUE_BITS-1:0]  val_ff;
   logic [IW-1:0]          idx_ff;
   logic [DEPTH-1:0]       lt_ff, eq_ff, dup_ff;
   logic [DEPTH-1:0]       lt_in, eq_in, dup_in;
   logic [PW-1:0]          pass_ff;
   sat_pkg::status_type    res_status_ff;
   logic [CW-1:0]          res_pos_ff;
   logic                   rsp_valid_ff;
   logic [sat_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   // decode
   logic [DEPTH-1:0]     valid;
   logic [DEPTH-1:0]     ge, ge_oh, eq_oh, dup_oh, swap_l;
   logic [CW-1:0]        ins_pos, find_pos, dup_pos;
   logic                 full, idx_gt, idx_ge, dup_hit, found;
   sat_pkg::status_type  ex_status;
   logic [CW-1:0]        ex_pos;
   logic                 do_ins, do_del, do_clr;
   logic [CW-1:0]        ins_at, del_at;
   logic                 ins_go, del_go, clr_go;

   assign req_cmd  = sat_pkg::cmd_type'(req_tdata[sat_pkg::CMD_W-1:0]);
   assign req_raw  = req_tdata[sat_pkg::CMD_W +: sat_pkg::VAL_IN_W];
   assign req_wide = 64'(req_raw);
   assign req_val  = req_wide[VALUE_BITS-1:0];
   assign req_idx  = req_tdata[sat_pkg::CMD_W + sat_pkg::VAL_IN_W +: sat_pkg::IDX_W];

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         valid[i] = CW'(i) < count_ff;
      end
   end

   // per-cell compares against the request value and the left neighbor
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         lt_in[i] = valid[i] && (cell_ff[i] < val_ff);
         eq_in[i] = valid[i] && (cell_ff[i] == val_ff);
      end
      dup_in[0] = 1'b0;
      for (int i = 1; i < DEPTH; i++) begin
         dup_in[i] = valid[i] && (cell_ff[i] == cell_ff[i-1]);
      end
   end

   // first-hit picks as one-hot vectors, then encode
   assign ge     = valid & ~lt_ff;
   assign ge_oh  = ge & (~ge + DEPTH'(1));
   assign eq_oh  = eq_ff & (~eq_ff + DEPTH'(1));
   assign dup_oh = dup_ff & (~dup_ff + DEPTH'(1));

   always_comb begin
      ins_pos  = (ge == '0) ? count_ff : '0;
      find_pos = '0;
      dup_pos  = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (ge_oh[i]) begin
            ins_pos = ins_pos | CW'(i);
         end
         if (eq_oh[i]) begin
            find_pos = find_pos | CW'(i);
         end
         if (dup_oh[i]) begin
            dup_pos = dup_pos | CW'(i);
         end
      end
   end

   assign full    = count_ff == CW'(DEPTH);
   assign idx_gt  = idx_ff > IW'(count_ff);
   assign idx_ge  = idx_ff >= IW'(count_ff);
   assign dup_hit = |(eq_ff & ge_oh);
   assign found   = |eq_ff;

   always_comb begin
      ex_status = sat_pkg::ST_OK;
      ex_pos    = '0;
      do_ins    = 1'b0;
      do_del    = 1'b0;
      do_clr    = 1'b0;
      ins_at    = '0;
      del_at    = '0;
      unique case (cmd_ff)
         sat_pkg::CMD_APPEND: begin
            if (full) begin
               ex_status = sat_pkg::ST_FULL;
            end else begin
               do_ins = 1'b1;
               ins_at = count_ff;
               ex_pos = count_ff;
            end
         end
         sat_pkg::CMD_INSERT_AT: begin
            priority if (idx_gt) begin
               ex_status = sat_pkg::ST_RANGE;
            end else if (full) begin
               ex_status = sat_pkg::ST_FULL;
            end else begin
               do_ins = 1'b1;
               ins_at = CW'(idx_ff);
               ex_pos = CW'(idx_ff);
            end
         end
         sat_pkg::CMD_INSERT_SORTED: begin
            if (full) begin
               ex_status = sat_pkg::ST_FULL;
            end else begin
               do_ins = 1'b1;
               ins_at = ins_pos;
               ex_pos = ins_pos;
            end
         end
         sat_pkg::CMD_INSERT_UNIQUE: begin
            priority if (dup_hit) begin
               ex_status = sat_pkg::ST_MISS;
            end else if (full) begin
               ex_status = sat_pkg::ST_FULL;
            end else begin
               do_ins = 1'b1;
               ins_at = ins_pos;
               ex_pos = ins_pos;
            end
         end
         sat_pkg::CMD_DELETE_AT: begin
            if (idx_ge) begin
               ex_status = sat_pkg::ST_RANGE;
            end else begin
               do_del = 1'b1;
               del_at = CW'(idx_ff);
            end
         end
         sat_pkg::CMD_FIND: begin
            if (found) begin
               ex_pos = find_pos;
            end else begin
               ex_status = sat_pkg::ST_MISS;
            end
         end
         sat_pkg::CMD_SORT_UNIQUE: begin
            ex_status = sat_pkg::ST_OK;
         end
         sat_pkg::CMD_CLEAR: begin
            do_clr = 1'b1;
         end
      endcase
   end

   assign ins_go = ctl.exec & do_ins;
   assign del_go = (ctl.exec & do_del) | ctl.dup_del;
   assign clr_go = ctl.exec & do_clr;

   // each cell takes the new value, shifts up, shifts down, swaps with a neighbor or holds
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam int PI = (i > 0) ? i - 1 : 0;
      localparam int NI = (i < DEPTH - 1) ? i + 1 : i;
      logic [CW-1:0] del_here;

      if (i < DEPTH - 1) begin : g_pair
         assign swap_l[i] = ctl.sort_step && (1'(i % 2) == pass_ff[0]) &&
                            (CW'(i + 1) < count_ff) && (cell_ff[i] > cell_ff[NI]);
      end else begin : g_end
         assign swap_l[i] = 1'b0;
      end

      assign del_here = ctl.dup_del ? dup_pos : del_at;

      always_comb begin
         cell_in[i] = cell_ff[i];
         priority if (ins_go && (CW'(i) == ins_at)) begin
            cell_in[i] = val_ff;
         end else if (ins_go && (CW'(i) > ins_at)) begin
            cell_in[i] = cell_ff[PI];
         end else if (del_go && (CW'(i) >= del_here) && (i < DEPTH - 1)) begin
            cell_in[i] = cell_ff[NI];
         end else if (swap_l[i]) begin
            cell_in[i] = cell_ff[NI];
         end else if ((i > 0) && swap_l[PI]) begin
            cell_in[i] = cell_ff[PI];
         end else begin
            cell_in[i] = cell_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         cell_ff[i] <= cell_in[i];
      end
   end

   always_comb begin
      count_in = count_ff;
      priority if (clr_go) begin
         count_in = '0;
      end else if (ins_go) begin
         count_in = count_ff + CW'(1);
      end else if (del_go) begin
         count_in = count_ff - CW'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (ctl.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.cap_req) begin
         cmd_ff <= req_cmd;
         val_ff <= req_val;
         idx_ff <= IW'(req_idx);
      end
      if (ctl.cmp) begin
         lt_ff  <= lt_in;
         eq_ff  <= eq_in;
         dup_ff <= dup_in;
      end
      if (ctl.exec) begin
         res_status_ff <= ex_status;
         res_pos_ff    <= ex_pos;
         pass_ff       <= '0;
      end else if (ctl.sort_step) begin
         pass_ff <= pass_ff + PW'(1);
      end
      if (ctl.load_rsp) begin
         rsp_data_ff <= {{sat_pkg::RSP_PAD_W{1'b0}},
                         sat_pkg::COUNT_W'(count_ff),
                         sat_pkg::POS_W'(res_pos_ff),
                         res_status_ff};
      end
   end

   assign sts.is_sort   = cmd_ff == sat_pkg::CMD_SORT_UNIQUE;
   assign sts.sort_last = pass_ff == PW'(DEPTH - 1);
   assign sts.dup_found = |dup_ff;
   assign sts.rsp_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### rtl/core/sorted_array_table_unit.sv
// Top level of the sorted array table: a bounded table of unsigned values.
//
// Usage: one command word enters on the req_ stream and exactly one result
// word leaves on the rsp_ stream. Commands: append, insert at a position,
// sorted insert, sorted insert without duplicates, delete at an index, find,
// sort with duplicates removed, and clear. The result carries a status, the
// position inserted or found, and the fill count after the command.
// Sequence: a command is taken only while the sequencer is idle, so one
// command is in flight at a time. Every command but sort steps through a
// compare in all cells, an execute step and a load of the output register,
// which raises rsp_tvalid; the sequencer then returns to idle and can take
// the next word. Sort runs DEPTH odd-even passes over the cells, then a
// compare and a delete step per duplicate removed and one last compare
// before the load of the output register. The per-cell compare and the
// first-hit pick over DEPTH flags set the pace.
// Stall: a result waiting in the output register holds while rsp_tready is
// low; the next command is still accepted and runs until its result is
// due, then waits for the register to drain.
// Reset: clears the fill count, the sequencer and the output valid; entry
// contents are left as they are and are only read below the fill count.
module sorted_array_table_unit #(
   parameter int DEPTH      = sat_pkg::DEPTH_DEF,
   parameter int VALUE_BITS = sat_pkg::VALUE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [2:0] command, [34:3] value, [39:35] index
   input  logic [sat_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [1:0] status, [6:2] position, [11:7] count, [15:12] zero
   output logic [sat_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   sat_pkg::ctl_type ctl;
   sat_pkg::sts_type sts;

   // sequencer: accepts a word, then walks compare, execute, sort and duplicate-removal phases
   sat_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   // cells, fill count and the output register
   sat_datapath #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .ctl        (ctl),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### rtl/core/sat_checker.sv
// Port-level checks of the sorted array table, bound to the top level.
`include "sorted_array_table_unit_defines.svh"

module sat_checker #(
   parameter int DEPTH = sat_pkg::DEPTH_DEF
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [sat_pkg::REQ_DATA_W-1:0]  req_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [sat_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   logic [sat_pkg::STATUS_W-1:0] rsp_status;
   logic [sat_pkg::POS_W-1:0]    rsp_pos;
   logic [sat_pkg::COUNT_W-1:0]  rsp_count;
   logic                         req_cmd_any;

   assign rsp_status  = rsp_tdata[1:0];
   assign rsp_pos     = rsp_tdata[6:2];
   assign rsp_count   = rsp_tdata[11:7];
   assign req_cmd_any = |req_tdata;

   `SAT_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result word changed while stalled")
   `SAT_ASSERT_NEXT(a_one_in_flight, req_tvalid && req_tready && (req_cmd_any || !req_cmd_any), !req_tready, "second word taken while a command is in flight")
   `SAT_ASSERT_SAME(a_fail_pos, rsp_tvalid && (rsp_status != sat_pkg::ST_OK), rsp_pos == '0, "failed command reported a nonzero position")
   `SAT_ASSERT_SAME(a_full_count, rsp_tvalid && (rsp_status == sat_pkg::ST_FULL), rsp_count == sat_pkg::COUNT_W'(DEPTH), "table full reported below capacity")

endmodule

bind sorted_array_table_unit sat_checker #(
   .DEPTH (DEPTH)
) u_sat_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### tb/sv/testbench.sv
// Self-checking testbench for the sorted array table unit.
module testbench;

   localparam int TBL_DEPTH    = sat_pkg::DEPTH_DEF;
   localparam int PHASE_ITEMS  = 90;
   localparam int BURST_ITEMS  = 15;
   localparam int DRAIN_CYCLES = 80;

   // idling modes for the two streams
   typedef enum int {
      PH_STEADY,
      PH_SEND_GAPS,
      PH_RECV_STALLS,
      PH_BOTH_IDLE
   } idle_mode_type;

   // command mix for a burst of random words
   typedef enum int {
      MIX_GROW,
      MIX_SHRINK,
      MIX_EVEN
   } cmd_mix_type;

   typedef struct {
      sat_pkg::cmd_type cmd;
      logic [31:0]      value;
      logic [4:0]       index;
   } table_cmd_type;

   typedef struct {
      sat_pkg::status_type status;
      logic [4:0]          position;
      logic [4:0]          count;
   } table_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // [2:0] command, [34:3] value, [39:35] index
   logic [sat_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // [1:0] status, [6:2] position, [11:7] count, [15:12] zero
   logic [sat_pkg::RSP_DATA_W-1:0] rsp_tdata;

   // shadow copy of the table
   logic [31:0] shadow_entries [TBL_DEPTH];
   int          shadow_fill = 0;

   table_cmd_type    pending_cmds [$];
   table_result_type expected_results [$];
   idle_mode_type    idle_mode = PH_STEADY;

   int error_count = 0;
   int words_queued = 0;
   int words_offered = 0;
   int words_sent = 0;
   int results_seen = 0;
   int status_hits [4] = '{0, 0, 0, 0};
   int peak_fill = 0;

   sorted_array_table_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Open a slot at pos, shifting later entries up, and store val there.
   function automatic void open_slot(int pos, logic [31:0] val);
      for (int i = shadow_fill; i > pos; i--) begin
         shadow_entries[i] = shadow_entries[i-1];
      end
      shadow_entries[pos] = val;
      shadow_fill++;
   endfunction

   // Apply one command to the shadow table and return the result it yields.
   function automatic table_result_type apply_table_cmd(table_cmd_type c);
      table_result_type r;
      bit               full;
      int               i;
      int               j;
      int               k;
      logic [31:0]      v;
      r.status   = sat_pkg::ST_OK;
      r.position = '0;
      full = shadow_fill >= TBL_DEPTH;
      case (c.cmd)
         sat_pkg::CMD_APPEND: begin
            if (full) begin
               r.status = sat_pkg::ST_FULL;
            end else begin
               r.position = 5'(shadow_fill);
               shadow_entries[shadow_fill] = c.value;
               shadow_fill++;
            end
         end
         sat_pkg::CMD_INSERT_AT: begin
            // range check wins over the full check
            if (int'(c.index) > shadow_fill) begin
               r.status = sat_pkg::ST_RANGE;
            end else if (full) begin
               r.status = sat_pkg::ST_FULL;
            end else begin
               r.position = c.index;
               open_slot(int'(c.index), c.value);
            end
         end
         sat_pkg::CMD_INSERT_SORTED, sat_pkg::CMD_INSERT_UNIQUE: begin
            i = 0;
            while (i < shadow_fill && shadow_entries[i] < c.value) i++;
            // duplicate check wins over the full check
            if (c.cmd == sat_pkg::CMD_INSERT_UNIQUE && i < shadow_fill
                && shadow_entries[i] == c.value) begin
               r.status = sat_pkg::ST_MISS;
            end else if (full) begin
               r.status = sat_pkg::ST_FULL;
            end else begin
               r.position = 5'(i);
               open_slot(i, c.value);
            end
         end
         sat_pkg::CMD_DELETE_AT: begin
            if (int'(c.index) >= shadow_fill) begin
               r.status = sat_pkg::ST_RANGE;
            end else begin
               for (i = int'(c.index); i + 1 < shadow_fill; i++) begin
                  shadow_entries[i] = shadow_entries[i+1];
               end
               shadow_fill--;
            end
         end
         sat_pkg::CMD_FIND: begin
            r.status = sat_pkg::ST_MISS;
            for (i = 0; i < shadow_fill; i++) begin
               if (shadow_entries[i] == c.value) begin
                  r.status   = sat_pkg::ST_OK;
                  r.position = 5'(i);
                  break;
               end
            end
         end
         sat_pkg::CMD_SORT_UNIQUE: begin
            if (shadow_fill > 0) begin
               for (i = 1; i < shadow_fill; i++) begin
                  v = shadow_entries[i];
                  j = i;
                  while (j > 0 && shadow_entries[j-1] > v) begin
                     shadow_entries[j] = shadow_entries[j-1];
                     j--;
                  end
                  shadow_entries[j] = v;
               end
               k = 0;
               for (i = 1; i < shadow_fill; i++) begin
                  if (shadow_entries[i] != shadow_entries[k]) begin
                     k++;
                     shadow_entries[k] = shadow_entries[i];
                  end
               end
               shadow_fill = k + 1;
            end
         end
         default: begin
            shadow_fill = 0;
         end
      endcase
      r.count = 5'(shadow_fill);
      return r;
   endfunction

   // Values lean toward a small pool so that duplicates and find hits are common.
   function automatic logic [31:0] pick_value();
      logic [31:0] corners [4] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                   32'h8000_0000, 32'h7FFF_FFFF};
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 5) return 32'($urandom_range(0, 7));
      if (roll == 5) return corners[$urandom_range(0, 3)];
      return $urandom();
   endfunction

   function automatic sat_pkg::cmd_type pick_cmd(cmd_mix_type mix);
      int roll;
      roll = $urandom_range(0, 99);
      case (mix)
         MIX_GROW: begin
            if (roll < 20) return sat_pkg::CMD_APPEND;
            if (roll < 40) return sat_pkg::CMD_INSERT_AT;
            if (roll < 60) return sat_pkg::CMD_INSERT_SORTED;
            if (roll < 80) return sat_pkg::CMD_INSERT_UNIQUE;
            if (roll < 88) return sat_pkg::CMD_FIND;
            if (roll < 94) return sat_pkg::CMD_DELETE_AT;
            if (roll < 98) return sat_pkg::CMD_SORT_UNIQUE;
            return sat_pkg::CMD_CLEAR;
         end
         MIX_SHRINK: begin
            if (roll < 10) return sat_pkg::CMD_APPEND;
            if (roll < 15) return sat_pkg::CMD_INSERT_AT;
            if (roll < 20) return sat_pkg::CMD_INSERT_SORTED;
            if (roll < 25) return sat_pkg::CMD_INSERT_UNIQUE;
            if (roll < 70) return sat_pkg::CMD_DELETE_AT;
            if (roll < 88) return sat_pkg::CMD_FIND;
            if (roll < 96) return sat_pkg::CMD_SORT_UNIQUE;
            return sat_pkg::CMD_CLEAR;
         end
         default: begin
            if (roll < 98) return sat_pkg::cmd_type'(roll % 7);
            return sat_pkg::CMD_CLEAR;
         end
      endcase
   endfunction

   task automatic queue_cmd(sat_pkg::cmd_type cmd, logic [31:0] value, logic [4:0] index);
      table_cmd_type c;
      c.cmd   = cmd;
      c.value = value;
      c.index = index;
      pending_cmds.push_back(c);
      words_queued++;
   endtask

   // Hold until every queued word came back as a result.
   task automatic wait_quiet();
      while (results_seen < words_queued) begin
         @(negedge clock);
      end
   endtask

   function automatic bit roll_idle(bit sender_side);
      int pct;
      pct = 0;
      case (idle_mode)
         PH_SEND_GAPS:   pct = sender_side ? 53 : 0;
         PH_RECV_STALLS: pct = sender_side ? 0 : 53;
         PH_BOTH_IDLE:   pct = 10;
         default:        pct = 0;
      endcase
      return $urandom_range(0, 99) < pct;
   endfunction

   // Driver: hold a word until it is taken, otherwise offer the next one or idle.
   always @(negedge clock) begin : req_driver
      table_cmd_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (words_sent < words_offered) begin
         req_tvalid <= 1'b1;
      end else if (pending_cmds.size() > 0 && !roll_idle(1'b1)) begin
         nxt = pending_cmds.pop_front();
         req_tdata  <= {nxt.index, nxt.value, nxt.cmd};
         req_tvalid <= 1'b1;
         words_offered++;
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   always @(negedge clock) begin : rsp_ready_driver
      rsp_tready <= reset ? 1'b0 : !roll_idle(1'b0);
   end

   // Predict at acceptance: the block runs one command at a time, in order.
   always @(posedge clock) begin : req_monitor
      table_cmd_type c;
      if (!reset && req_tvalid && req_tready) begin
         c.cmd   = sat_pkg::cmd_type'(req_tdata[2:0]);
         c.value = req_tdata[34:3];
         c.index = req_tdata[39:35];
         expected_results.push_back(apply_table_cmd(c));
         if (shadow_fill > peak_fill) peak_fill = shadow_fill;
         words_sent++;
      end
   end

   // Compare each result word field by field with the oldest prediction.
   always @(posedge clock) begin : rsp_monitor
      table_result_type    want;
      sat_pkg::status_type got_status;
      logic [4:0]          got_position;
      logic [4:0]          got_count;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_status   = sat_pkg::status_type'(rsp_tdata[1:0]);
         got_position = rsp_tdata[6:2];
         got_count    = rsp_tdata[11:7];
         results_seen++;
         if (expected_results.size() == 0) begin
            error_count++;
            $display("%0t: expected no result word, got %h", $time, rsp_tdata);
         end else begin
            want = expected_results.pop_front();
            status_hits[want.status]++;
            if (got_status != want.status || got_position != want.position
                || got_count != want.count || rsp_tdata[15:12] != '0) begin
               error_count++;
               $display("%0t: mismatch expected %s pos %0d count %0d,",
                        $time, want.status.name(), want.position, want.count);
               $display("      got %s pos %0d count %0d pad %h",
                        got_status.name(), got_position, got_count,
                        rsp_tdata[15:12]);
            end
         end
      end
   end

   initial begin : run_limit
      #2000000;
      $display("sorted_array_table_unit verification failed");
      $finish;
   end

   initial begin : stimulus
      idle_mode_type modes [5] = '{PH_STEADY, PH_SEND_GAPS, PH_RECV_STALLS,
                                   PH_BOTH_IDLE, PH_STEADY};
      cmd_mix_type mix;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // empty table: clear, delete past end, insert past end
      queue_cmd(sat_pkg::CMD_CLEAR, 32'h0, 5'd0);
      queue_cmd(sat_pkg::CMD_DELETE_AT, 32'h0, 5'd0);
      queue_cmd(sat_pkg::CMD_INSERT_AT, 32'h1234_5678, 5'd1);
      // every insert kind with corner values, one refused duplicate
      queue_cmd(sat_pkg::CMD_APPEND, 32'h0000_0000, 5'd0);
      queue_cmd(sat_pkg::CMD_APPEND, 32'hFFFF_FFFF, 5'd0);
      queue_cmd(sat_pkg::CMD_INSERT_AT, 32'h8000_0000, 5'd0);
      queue_cmd(sat_pkg::CMD_INSERT_AT, 32'h7FFF_FFFF, 5'd3);
      queue_cmd(sat_pkg::CMD_INSERT_SORTED, 32'd5, 5'd0);
      queue_cmd(sat_pkg::CMD_INSERT_UNIQUE, 32'd5, 5'd0);
      queue_cmd(sat_pkg::CMD_INSERT_UNIQUE, 32'd6, 5'd0);
      // fill to the top with duplicates for the later sort
      for (int i = 0; i < 10; i++) begin
         if (i % 2 == 1) begin
            queue_cmd(sat_pkg::CMD_INSERT_SORTED, 32'(i % 3 + 1), 5'd0);
         end else begin
            queue_cmd(sat_pkg::CMD_APPEND, 32'(i % 3 + 1), 5'd0);
         end
      end
      // full table: refusals, duplicate before full, then shrink
      queue_cmd(sat_pkg::CMD_APPEND, 32'd9, 5'd0);
      queue_cmd(sat_pkg::CMD_INSERT_AT, 32'd9, 5'd16);
      queue_cmd(sat_pkg::CMD_INSERT_UNIQUE, 32'd5, 5'd0);
      queue_cmd(sat_pkg::CMD_INSERT_UNIQUE, 32'd9, 5'd0);
      queue_cmd(sat_pkg::CMD_FIND, 32'h7FFF_FFFF, 5'd0);
      queue_cmd(sat_pkg::CMD_DELETE_AT, 32'h0, 5'd16);
      queue_cmd(sat_pkg::CMD_DELETE_AT, 32'h0, 5'd0);
      queue_cmd(sat_pkg::CMD_SORT_UNIQUE, 32'h0, 5'd0);
      queue_cmd(sat_pkg::CMD_FIND, 32'h0001_2345, 5'd0);
      queue_cmd(sat_pkg::CMD_CLEAR, 32'h0, 5'd0);
      wait_quiet();

      // random bursts, each leaning toward growth, shrinkage or an even mix
      foreach (modes[m]) begin
         idle_mode = modes[m];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % BURST_ITEMS == 0) mix = cmd_mix_type'($urandom_range(0, 2));
            queue_cmd(pick_cmd(mix), pick_value(), 5'($urandom_range(0, 16)));
         end
         wait_quiet();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d command words, checked %0d results, peak fill %0d of %0d.",
               words_sent, results_seen, peak_fill, TBL_DEPTH);
      $display("Status mix: ok %0d, miss/duplicate %0d, full %0d, out of range %0d.",
               status_hits[sat_pkg::ST_OK], status_hits[sat_pkg::ST_MISS],
               status_hits[sat_pkg::ST_FULL], status_hits[sat_pkg::ST_RANGE]);
      if (error_count == 0 && expected_results.size() == 0
          && results_seen == words_queued) begin
         $display("sorted_array_table_unit verification clean");
      end else begin
         $display("sorted_array_table_unit verification failed");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/sat_pkg.sv
rtl/core/sat_ctrl.sv
rtl/core/sat_datapath.sv
rtl/core/sorted_array_table_unit.sv
rtl/core/sat_checker.sv
tb/sv/testbench.sv
